>>> hdl/bdel_pkg.sv
// Shared types and constants for the button debounce / press latch block.
// No dependencies; imported by every module of the block.
package bdel_pkg;

  localparam int NUM_BUTTONS_DEF = 3;
  localparam int FIELD_W         = 3;   // width of opcode, raw and number fields
  localparam int SHOWN_BUTTONS   = 3;   // buttons visible in input and result fields
  localparam int CNT_W           = 8;
  localparam int CFG_IDX_W       = 8;
  localparam int IN_DATA_W       = 16;
  localparam int OUT_DATA_W      = 8;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd10;
  localparam logic [CNT_W-1:0] PRESCALE_RESET = 8'd10;

  typedef enum logic [FIELD_W-1:0] {
    OP_TICK      = 3'd0,
    OP_GET_PUSH  = 3'd1,
    OP_GET_PREL  = 3'd2,
    OP_GET_STATE = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_RESET     = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TIME   = 8'd0,
    REG_PRESCALE_PERIOD = 8'd1
  } cfg_reg_t;

  // control broadcast from the top level to every lane
  typedef struct packed {
    logic             fire;       // request accepted this cycle
    logic [FIELD_W-1:0] op;
    logic             pre_zero;   // prescaler is zero after this tick
    logic [CNT_W-1:0] debounce_time;
  } lane_ctl_t;

  // what one lane reports for the current request
  typedef struct packed {
    logic answer;
    logic stable;    // stable state after the request
    logic latched;   // latched press after the request
  } lane_res_t;

endpackage

>>> hdl/bdel_lane.sv
// One button lane: raw sample, lockout countdown, pending and latched press.
// Depends on bdel_pkg for lane_ctl_t, lane_res_t and the opcodes.
module bdel_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  bdel_pkg::lane_ctl_t ctl,
  input  logic               sel,    // this lane is the queried button
  input  logic               raw,    // sampled input, 1 = pressed
  output bdel_pkg::lane_res_t res
);
  import bdel_pkg::*;

  logic             raw_r, raw_nxt;
  logic [CNT_W-1:0] lock_r, lock_nxt;
  logic             pend_r, pend_nxt;
  logic             latch_r, latch_nxt;
  logic             stable_r, stable_nxt;
  logic             answer;

  always_comb begin
    raw_nxt    = raw_r;
    lock_nxt   = lock_r;
    pend_nxt   = pend_r;
    latch_nxt  = latch_r;
    stable_nxt = stable_r;
    answer     = 1'b0;
    unique case (op_t'(ctl.op))
      OP_TICK: begin
        if (raw != raw_r) begin
          raw_nxt = raw;
          if (lock_r == '0) begin
            if (!raw) lock_nxt = ctl.debounce_time;
            else      pend_nxt = 1'b1;
          end
        end else begin
          if (ctl.pre_zero && (lock_r != '0)) lock_nxt = lock_r - 1'b1;
          latch_nxt  = latch_r | pend_r;
          pend_nxt   = 1'b0;
          stable_nxt = raw_r;
        end
      end
      OP_GET_PUSH: begin
        if (sel) begin
          answer    = latch_r;
          latch_nxt = 1'b0;
        end
      end
      OP_GET_PREL: begin
        if (sel && latch_r && !stable_r) begin
          answer    = 1'b1;
          latch_nxt = 1'b0;
        end
      end
      OP_GET_STATE: begin
        if (sel) answer = stable_r;
      end
      OP_CLEAR: latch_nxt = 1'b0;
      OP_RESET: begin
        raw_nxt   = 1'b0;
        lock_nxt  = ctl.debounce_time;
        pend_nxt  = 1'b0;
        latch_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      lock_r   <= DEBOUNCE_RESET;
      pend_r   <= 1'b0;
      latch_r  <= 1'b0;
      stable_r <= 1'b0;
    end else if (ctl.fire) begin
      raw_r    <= raw_nxt;
      lock_r   <= lock_nxt;
      pend_r   <= pend_nxt;
      latch_r  <= latch_nxt;
      stable_r <= stable_nxt;
    end
  end

  assign res.answer  = answer;
  assign res.stable  = stable_nxt;
  assign res.latched = latch_nxt;

endmodule

>>> hdl/bdel_merge.sv
// Merge stage: ORs the lane answers, packs the visible lanes, and holds the
// result in the output register. Depends on bdel_pkg.
module bdel_merge #(
  parameter int NUM_BUTTONS = bdel_pkg::NUM_BUTTONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               fire,
  input  bdel_pkg::lane_res_t                lane_res [NUM_BUTTONS],
  output logic                               free,   // output register can load
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata: [0] answer, [3:1] stable_states, [6:4] latched_presses, [7] zero
  output logic [bdel_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import bdel_pkg::*;

  logic                     answer;
  logic [SHOWN_BUTTONS-1:0] stable_v, latched_v;
  logic                     valid_r;
  logic [OUT_DATA_W-1:0]    data_r;

  always_comb begin
    answer = 1'b0;
    for (int k = 0; k < NUM_BUTTONS; k++) answer = answer | lane_res[k].answer;
  end

  for (genvar k = 0; k < SHOWN_BUTTONS; k++) begin : g_pack
    if (k < NUM_BUTTONS) begin : g_on
      assign stable_v[k]  = lane_res[k].stable;
      assign latched_v[k] = lane_res[k].latched;
    end else begin : g_off
      assign stable_v[k]  = 1'b0;
      assign latched_v[k] = 1'b0;
    end
  end

  assign free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) data_r <= {1'b0, latched_v, stable_v, answer};
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

>>> hdl/button_debounce_edge_latch.sv
// Top level of the push-button debouncer with press latch.
// Depends on bdel_pkg, bdel_lane and bdel_merge.
//
// Each request (tick, query, clear or reset) yields exactly one result, which
// appears in the output register in the cycle after the request is taken; a new
// request is accepted every cycle as long as the result side keeps up
// (in_tready drops only while a result waits and out_tready is low). Every
// button has its own lane that updates raw sample, lockout countdown and
// press flags in next-state logic; the shared prescaler sits here, and the
// merge stage ORs lane answers and packs the first three lanes into the
// result. Queries use one-based button numbers; a number of zero or above
// NUM_BUTTONS answers 0. Registers: index 0 debounce_time, index 1
// prescale_period, both reset to 10; writes to other indexes are dropped.
// The configuration port is always ready.
module button_debounce_edge_latch #(
  parameter int NUM_BUTTONS = bdel_pkg::NUM_BUTTONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: [2:0] opcode, [5:3] raw_pressed, [8:6] button_number, [15:9] zero
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bdel_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: [0] answer, [3:1] stable_states, [6:4] latched_presses, [7] zero
  output logic [bdel_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bdel_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdel_pkg::CNT_W-1:0]      cfg_data
);
  import bdel_pkg::*;

  logic [FIELD_W-1:0] in_op, in_raw, in_num;
  logic               fire, free;
  logic [CNT_W-1:0]   debounce_r, prescale_r;
  logic [CNT_W-1:0]   pre_r, pre_nxt;
  lane_ctl_t          ctl;
  lane_res_t          lane_res [NUM_BUTTONS];

  assign in_op  = in_tdata[FIELD_W-1:0];
  assign in_raw = in_tdata[2*FIELD_W-1:FIELD_W];
  assign in_num = in_tdata[3*FIELD_W-1:2*FIELD_W];

  assign in_tready = free;
  assign fire      = in_tvalid && free;
  assign cfg_ready = 1'b1;

  // config registers; only to be written while idle, a rule on the user that the block does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      prescale_r <= PRESCALE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DEBOUNCE_TIME)   debounce_r <= cfg_data;
      if (cfg_index == REG_PRESCALE_PERIOD) prescale_r <= cfg_data;
    end
  end

  // shared prescaler steps on every tick; lanes see its new value
  assign pre_nxt = (pre_r != '0) ? pre_r - 1'b1 : prescale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r <= '0;
    end else if (fire && (in_op == OP_TICK)) begin
      pre_r <= pre_nxt;
    end
  end

  assign ctl.fire          = fire;
  assign ctl.op            = in_op;
  assign ctl.pre_zero      = (pre_nxt == '0);
  assign ctl.debounce_time = debounce_r;

  for (genvar k = 0; k < NUM_BUTTONS; k++) begin : g_lane
    logic raw_bit;
    if (k < SHOWN_BUTTONS) begin : g_in
      assign raw_bit = in_raw[k];
    end else begin : g_none
      assign raw_bit = 1'b0;   // no input pin for this button
    end

    bdel_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .sel   (in_num == FIELD_W'(k + 1)),
      .raw   (raw_bit),
      .res   (lane_res[k])
    );
  end

  bdel_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .lane_res   (lane_res),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
